FILE: rtl/lrtm_pkg.sv
package lrtm_pkg;

   localparam int ORDER       = 5;
   localparam int VALUE_WIDTH = 24;
   localparam int INDEX_WIDTH = 63;
   localparam int NUM_REGS    = ORDER + 1;
   localparam int CSR_IW      = $clog2(NUM_REGS);
   localparam int CW          = (ORDER > 1) ? $clog2(ORDER) : 1;
   localparam int MAT         = ORDER * ORDER;
   localparam int MIW         = $clog2(MAT);
   localparam int BW          = $clog2(VALUE_WIDTH);
   localparam int REQ_TW      = ((INDEX_WIDTH + 7) / 8) * 8;
   localparam int RSP_TW      = ((VALUE_WIDTH + 7) / 8) * 8;

   localparam logic [VALUE_WIDTH-1:0] MODULUS_RESET = VALUE_WIDTH'(10000007);

   localparam logic [CSR_IW-1:0] REG_MODULUS = CSR_IW'(0);

   typedef enum logic [3:0] {
      S_IDLE, S_FETCH_A, S_FETCH_B, S_MUL, S_SUM, S_COPY, S_STEP, S_SHIFT, S_DONE
   } state_type;

   typedef enum logic [2:0] {
      K_SEED, K_RED, K_ACC, K_SQR, K_DOT
   } kind_type;

   // initial terms 1,2,3,2,1; also the reset weights
   function automatic logic [VALUE_WIDTH-1:0] seed_term(input logic [CW-1:0] idx);
      logic [VALUE_WIDTH-1:0] v;
      case (idx)
         CW'(0): v = VALUE_WIDTH'(1);
         CW'(1): v = VALUE_WIDTH'(2);
         CW'(2): v = VALUE_WIDTH'(3);
         CW'(3): v = VALUE_WIDTH'(2);
         CW'(4): v = VALUE_WIDTH'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/linear_recurrence_term_mod_top.sv
// linear recurrence term engine, modulo a programmable modulus
// request channel (req_): one term index per request, accepted when
//   req_tvalid and req_tready are high at a rising clock edge
// response channel (rsp_): one term value per request, in order
// csr_ port: write enable, register index, data; 0 modulus, 1..5 weights
// index handling: a zero index or a modulus below two goes straight
//   to the done state; indices 1..5 take one modular multiply of the
//   initial term by one; larger indices use square-and-multiply of the
//   5x5 companion matrix on one bit-serial modular multiplier, with
//   operand fetch and accumulate around each product; each matrix
//   product ends with a copy of the result matrix, and an exponent of
//   b bits costs up to 2*b-1 products plus the weight reduction and
//   final dot product
// throughput: one request at a time; req_tready is high only when idle
// a finished result sits in the response register; while the receiver
//   stalls the next request is still taken and computed, and it waits
//   in a done state until the response register frees up
// reset: synchronous, active high; registers return to their defaults
//   (modulus 10000007, weights 1,2,3,2,1), no response is pending
module linear_recurrence_term_mod_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [lrtm_pkg::REQ_TW-1:0]             req_tdata,  // term_index
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [lrtm_pkg::RSP_TW-1:0]             rsp_tdata,  // term_value
   input  logic                                    csr_wen,
   input  logic [lrtm_pkg::CSR_IW-1:0]             csr_index,
   input  logic [lrtm_pkg::VALUE_WIDTH-1:0]        csr_data
);
   import lrtm_pkg::*;

   localparam int VW = VALUE_WIDTH;

   // configuration registers
   logic [VW-1:0] modulus_ff;
   logic [VW-1:0] coef_ff [ORDER];

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET;
         for (int c = 0; c < ORDER; c++) begin
            coef_ff[c] <= seed_term(CW'(c));
         end
      end else if (csr_wen) begin
         if (csr_index == REG_MODULUS) begin
            modulus_ff <= csr_data;
         end else if ({1'b0, csr_index} <= (CSR_IW + 1)'(ORDER)) begin
            coef_ff[CW'(csr_index - CSR_IW'(1))] <= csr_data;
         end
      end
   end

   // sequencer state
   state_type            state_ff, state_in;
   kind_type             kind_ff, kind_in;
   logic [CW-1:0]        i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [BW-1:0]        cnt_ff, cnt_in;
   logic [INDEX_WIDTH-1:0] e_ff, e_in;
   logic [VW-1:0]        op_a_ff, op_a_in, op_b_ff, op_b_in;
   logic [VW-1:0]        r_ff, r_in, sum_ff, sum_in, res_ff, res_in;
   logic [VW-1:0]        base_ff [MAT], base_in [MAT];
   logic [VW-1:0]        acc_ff  [MAT], acc_in  [MAT];
   logic [VW-1:0]        tmp_ff  [MAT], tmp_in  [MAT];
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]        rsp_data_ff, rsp_data_in;

   logic [INDEX_WIDTH-1:0] n;
   logic [VW:0]          dbl, dbl_red, add, add_red, s_raw;
   logic [VW-1:0]        mul_next, s_mod;
   logic [MIW-1:0]       idx_ik, idx_kj, idx_ij;

   assign n = req_tdata[INDEX_WIDTH-1:0];
   assign idx_ik = MIW'(i_ff * ORDER + k_ff);
   assign idx_kj = MIW'(k_ff * ORDER + j_ff);
   assign idx_ij = MIW'(i_ff * ORDER + j_ff);

   // shared unit: one step of interleaved shift-add modular multiply
   always_comb begin
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, modulus_ff}) ? dbl - {1'b0, modulus_ff} : dbl;
      add     = dbl_red + {1'b0, op_b_ff};
      if (op_a_ff[cnt_ff]) begin
         add_red = (add >= {1'b0, modulus_ff}) ? add - {1'b0, modulus_ff} : add;
      end else begin
         add_red = dbl_red;
      end
      mul_next = add_red[VW-1:0];
      // modular accumulate of the finished product
      s_raw = {1'b0, sum_ff} + {1'b0, r_ff};
      s_mod = (s_raw >= {1'b0, modulus_ff}) ? VW'(s_raw - {1'b0, modulus_ff})
                                            : s_raw[VW-1:0];
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TW'(rsp_data_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      cnt_ff      <= cnt_in;
      e_ff        <= e_in;
      op_a_ff     <= op_a_in;
      op_b_ff     <= op_b_in;
      r_ff        <= r_in;
      sum_ff      <= sum_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      base_ff     <= base_in;
      acc_ff      <= acc_in;
      tmp_ff      <= tmp_in;
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      e_in         = e_ff;
      op_a_in      = op_a_ff;
      op_b_in      = op_b_ff;
      r_in         = r_ff;
      sum_in       = sum_ff;
      res_in       = res_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      tmp_in       = tmp_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (modulus_ff < VW'(2) || n == '0) begin
                  res_in   = '0;
                  state_in = S_DONE;
               end else if (n <= INDEX_WIDTH'(ORDER)) begin
                  // initial term, reduced by multiplying with one
                  kind_in  = K_SEED;
                  op_a_in  = seed_term(CW'(n - INDEX_WIDTH'(1)));
                  op_b_in  = VW'(1);
                  state_in = S_FETCH_B;
               end else begin
                  e_in    = n - INDEX_WIDTH'(ORDER);
                  kind_in = K_RED;
                  j_in    = '0;
                  for (int a = 0; a < ORDER; a++) begin
                     for (int b = 0; b < ORDER; b++) begin
                        acc_in[a*ORDER+b] = (a == b) ? VW'(1) : '0;
                        if (a > 0) begin
                           base_in[a*ORDER+b] = (b == a - 1) ? VW'(1) : '0;
                        end
                     end
                  end
                  state_in = S_FETCH_A;
               end
            end
         end
         S_FETCH_A: begin
            case (kind_ff)
               K_RED: begin
                  op_a_in = coef_ff[j_ff];
                  op_b_in = VW'(1);
               end
               K_DOT: begin
                  op_a_in = seed_term(CW'(ORDER - 1) - j_ff);
                  op_b_in = acc_ff[MIW'(j_ff)];
               end
               K_ACC:   op_a_in = acc_ff[idx_ik];
               default: op_a_in = base_ff[idx_ik];
            endcase
            state_in = S_FETCH_B;
         end
         S_FETCH_B: begin
            if (kind_ff == K_ACC || kind_ff == K_SQR) begin
               op_b_in = base_ff[idx_kj];
            end
            r_in     = '0;
            cnt_in   = BW'(VW - 1);
            state_in = S_MUL;
         end
         S_MUL: begin
            r_in = mul_next;
            if (cnt_ff == '0) begin
               state_in = S_SUM;
            end else begin
               cnt_in = cnt_ff - BW'(1);
            end
         end
         S_SUM: begin
            case (kind_ff)
               K_SEED: begin
                  res_in   = r_ff;
                  state_in = S_DONE;
               end
               K_RED: begin
                  base_in[MIW'(j_ff)] = r_ff;
                  if (j_ff == CW'(ORDER - 1)) begin
                     state_in = S_STEP;
                  end else begin
                     j_in     = j_ff + CW'(1);
                     state_in = S_FETCH_A;
                  end
               end
               K_DOT: begin
                  if (j_ff == CW'(ORDER - 1)) begin
                     res_in   = s_mod;
                     state_in = S_DONE;
                  end else begin
                     sum_in   = s_mod;
                     j_in     = j_ff + CW'(1);
                     state_in = S_FETCH_A;
                  end
               end
               default: begin
                  state_in = S_FETCH_A;
                  if (k_ff == CW'(ORDER - 1)) begin
                     tmp_in[idx_ij] = s_mod;
                     sum_in = '0;
                     k_in   = '0;
                     if (j_ff == CW'(ORDER - 1)) begin
                        j_in = '0;
                        if (i_ff == CW'(ORDER - 1)) begin
                           i_in     = '0;
                           state_in = S_COPY;
                        end else begin
                           i_in = i_ff + CW'(1);
                        end
                     end else begin
                        j_in = j_ff + CW'(1);
                     end
                  end else begin
                     sum_in = s_mod;
                     k_in   = k_ff + CW'(1);
                  end
               end
            endcase
         end
         S_COPY: begin
            if (kind_ff == K_ACC) begin
               acc_in   = tmp_ff;
               state_in = S_SHIFT;
            end else begin
               base_in  = tmp_ff;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            // multiply into the accumulator when the exponent bit is set
            if (e_ff[0]) begin
               kind_in  = K_ACC;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               sum_in   = '0;
               state_in = S_FETCH_A;
            end else begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            e_in   = e_ff >> 1;
            i_in   = '0;
            j_in   = '0;
            k_in   = '0;
            sum_in = '0;
            state_in = S_FETCH_A;
            if ((e_ff >> 1) != '0) begin
               kind_in = K_SQR;
            end else begin
               kind_in = K_DOT;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("request taken while busy");
   a_mul_flow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |=> (state_ff == S_MUL || state_ff == S_SUM))
      else $error("multiplier left early");
   a_mul_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> (r_ff < modulus_ff && op_b_ff < modulus_ff))
      else $error("multiplier operand not reduced");
   a_rsp_reduced: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && modulus_ff >= VW'(2)) |-> (rsp_data_ff < modulus_ff))
      else $error("response not reduced");
`endif

endmodule
